@@ src/arkw_pkg.sv @@
// Package for the angle/rate Kalman filter: fixed-point constants, sequencer
// state type and the saturating helpers. No dependencies.
package arkw_pkg;

  localparam int WordWidth = 32;
  localparam int FracBits  = 24;
  localparam int CfgWidth  = 25;
  localparam int SumWidth  = 36;
  localparam int DivBits   = WordWidth + FracBits;
  localparam int CntWidth  = $clog2(DivBits);

  localparam logic signed [WordWidth-1:0] PiQ      = 32'sd52707179;
  localparam logic signed [SumWidth-1:0]  PiW      = 36'sd52707179;
  localparam logic signed [SumWidth-1:0]  TwoPiW   = 36'sd105414358;
  localparam logic signed [WordWidth-1:0] CovReset = 32'sd16777;

  localparam logic [2:0] RegAngleProc = 3'd0;
  localparam logic [2:0] RegRateProc  = 3'd1;
  localparam logic [2:0] RegAngleMeas = 3'd2;
  localparam logic [2:0] RegRateMeas  = 3'd3;
  localparam logic [2:0] RegPeriod    = 3'd4;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MULP = 6'b000010,
    S_MULW = 6'b000100,
    S_DIVL = 6'b001000,
    S_DIVR = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  function automatic logic signed [WordWidth-1:0] sat_w(input logic signed [SumWidth-1:0] v);
    logic signed [SumWidth-1:0] hi;
    logic signed [SumWidth-1:0] lo;
    hi = SumWidth'(32'sh7fffffff);
    lo = -hi - 36'sd1;
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[WordWidth-1:0];
  endfunction

  function automatic logic [WordWidth-1:0] mag_of(input logic signed [WordWidth-1:0] v);
    return v[WordWidth-1] ? (~v + 32'd1) : v;
  endfunction

  // magnitude capped at 2^31, then signed and saturated
  function automatic logic signed [WordWidth-1:0] signed_cap(input logic big,
                                                             input logic [WordWidth-1:0] m,
                                                             input logic neg);
    logic [WordWidth:0] c;
    c = big ? 33'h100000000 >> 1 : {1'b0, m};
    if (c[WordWidth-1] && c[WordWidth-2:0] == '0) c = 33'h080000000;
    if (neg) return WordWidth'(33'd0 - c);
    else if (c[WordWidth-1]) return 32'sh7fffffff;
    else return c[WordWidth-1:0];
  endfunction

  function automatic logic signed [WordWidth-1:0] qmul_fin(input logic [63:0] p, input logic neg);
    return signed_cap(p[63:55] != '0, {1'b0, p[54:FracBits]}, neg);
  endfunction

endpackage

@@ src/angle_rate_kalman_with_wrap.sv @@
// Top level of the two-state angle/rate Kalman filter with angle wrap.
// Depends on arkw_pkg.
//
// One item (measured angle and rate) yields one item (wrapped angle, rate).
// The block works on one item at a time: ten 32x32 products through one
// shared multiplier, each in a multiply state and a write-back state, two
// gain divisions through one restoring divider at one quotient bit per cycle
// after a load state, one state to take the item and one to hand over
// the result. A finished item waits in the output register, so the
// next item is taken while it is still unread. Registers sit at byte
// addresses 0,4,8,12,16 and hold 25 bits each.
module angle_rate_kalman_with_wrap (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [4:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [31:0]             measured_angle,
  input  logic signed [31:0]             measured_rate,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [26:0]             angle_estimate,
  output logic signed [31:0]             rate_estimate
);
  import arkw_pkg::*;

  localparam logic [3:0] StepLastPredict = 4'd3;
  localparam logic [3:0] StepAngle       = 4'd4;
  localparam logic [3:0] StepLast        = 4'd9;

  logic [CfgWidth-1:0] apn, rpn, amn, rmn, dt;
  state_t state;
  logic [3:0] step;
  logic dsel;
  logic signed [WordWidth-1:0] ang, rat, p00, p01, p10, p11;
  logic signed [WordWidth-1:0] za, zr, a, r, t, t2, q00, q01, q10, q11, k0, k1;
  logic [63:0] prod;
  logic pneg;
  logic signed [WordWidth-1:0] ma, mb, m;
  logic [WordWidth-1:0] dvs;
  logic [DivBits-1:0] dvd, quo;
  logic [WordWidth-1:0] rem;
  logic dneg, dzero;
  logic [CntWidth-1:0] cnt;
  logic [WordWidth:0] rsh;
  logic rge;
  logic [DivBits-1:0] quo_next;
  logic signed [WordWidth-1:0] kq;
  logic signed [SumWidth-1:0] psum, diff, zw;
  logic signed [WordWidth-1:0] dnum, dden, innov, a2;
  logic signed [SumWidth-1:0] aw;

  assign pready = 1'b1;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      RegAngleProc: prdata = 32'(apn);
      RegRateProc:  prdata = 32'(rpn);
      RegAngleMeas: prdata = 32'(amn);
      RegRateMeas:  prdata = 32'(rmn);
      RegPeriod:    prdata = 32'(dt);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    psum  = SumWidth'(q00) + SumWidth'(q01) + SumWidth'(q10) + SumWidth'(q11);
    diff  = SumWidth'(za) - SumWidth'(a);
    zw    = SumWidth'(za);
    if (diff > PiW) zw = SumWidth'(za) - TwoPiW;
    else if (diff < -PiW) zw = SumWidth'(za) + TwoPiW;
    innov = sat_w(zw - SumWidth'(a));
    if (!dsel) begin
      dnum = sat_w(SumWidth'(q00) + SumWidth'(q01));
      dden = sat_w(psum + SumWidth'(amn));
    end else begin
      dnum = sat_w(SumWidth'(q10) + SumWidth'(q11));
      dden = sat_w(psum + SumWidth'(rmn));
    end
  end

  always_comb begin
    ma = rat;
    mb = WordWidth'(dt);
    unique case (step)
      4'd0: begin ma = rat; mb = WordWidth'(dt); end
      4'd1: begin ma = p11; mb = WordWidth'(dt); end
      4'd2: begin ma = t;   mb = WordWidth'(dt); end
      4'd3: begin ma = sat_w(SumWidth'(p01) + SumWidth'(p10)); mb = WordWidth'(dt); end
      4'd4: begin ma = k0;  mb = innov; end
      4'd5: begin ma = k1;  mb = sat_w(SumWidth'(zr) - SumWidth'(rat)); end
      4'd6: begin ma = k0;  mb = q00; end
      4'd7: begin ma = k0;  mb = q01; end
      4'd8: begin ma = k1;  mb = q10; end
      4'd9: begin ma = k1;  mb = q11; end
      default: begin ma = rat; mb = WordWidth'(dt); end
    endcase
  end

  always_comb begin
    m  = qmul_fin(prod, pneg);
    aw = SumWidth'(sat_w(SumWidth'(a) + SumWidth'(m)));
    if (aw > PiW) aw = aw - TwoPiW;
    if (aw < -PiW) aw = aw + TwoPiW;
    if (aw > PiW) aw = PiW;
    if (aw < -PiW) aw = -PiW;
    a2 = aw[WordWidth-1:0];
  end

  always_comb begin
    rsh      = {rem, dvd[DivBits-1]};
    rge      = (rsh >= {1'b0, dvs});
    quo_next = {quo[DivBits-2:0], rge};
    kq       = dzero ? '0 : signed_cap(quo_next[DivBits-1:WordWidth-1] != '0,
                                       {1'b0, quo_next[WordWidth-2:0]}, dneg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      apn <= 25'd167772;
      rpn <= 25'd201327;
      amn <= 25'd16777;
      rmn <= 25'd50332;
      dt  <= 25'd16777;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[4:2])
        RegAngleProc: apn <= pwdata[CfgWidth-1:0];
        RegRateProc:  rpn <= pwdata[CfgWidth-1:0];
        RegAngleMeas: amn <= pwdata[CfgWidth-1:0];
        RegRateMeas:  rmn <= pwdata[CfgWidth-1:0];
        RegPeriod:    dt  <= pwdata[CfgWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      dsel      <= 1'b0;
      out_valid <= 1'b0;
      ang <= '0;
      rat <= '0;
      p00 <= CovReset;
      p01 <= CovReset;
      p10 <= CovReset;
      p11 <= CovReset;
    end else begin
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            za    <= measured_angle;
            zr    <= measured_rate;
            step  <= '0;
            state <= S_MULP;
          end
        end
        S_MULP: begin
          prod  <= 64'(mag_of(ma)) * 64'(mag_of(mb));
          pneg  <= ma[WordWidth-1] != mb[WordWidth-1];
          state <= S_MULW;
        end
        S_MULW: begin
          unique case (step)
            4'd0: a  <= sat_w(SumWidth'(ang) + SumWidth'(m));
            4'd1: t  <= m;
            4'd2: t2 <= m;
            4'd3: begin
              q00 <= sat_w(SumWidth'(p00) + SumWidth'(apn) + SumWidth'(m) + SumWidth'(t2));
              q01 <= sat_w(SumWidth'(p01) + SumWidth'(t));
              q10 <= sat_w(SumWidth'(p10) + SumWidth'(t));
              q11 <= sat_w(SumWidth'(p11) + SumWidth'(rpn));
            end
            4'd4: a   <= a2;
            4'd5: r   <= sat_w(SumWidth'(rat) + SumWidth'(m));
            4'd6: p00 <= sat_w(SumWidth'(q00) - SumWidth'(m));
            4'd7: p01 <= sat_w(SumWidth'(q01) - SumWidth'(m));
            4'd8: p10 <= sat_w(SumWidth'(q10) - SumWidth'(m));
            4'd9: p11 <= sat_w(SumWidth'(q11) - SumWidth'(m));
            default: ;
          endcase
          step <= step + 4'd1;
          if (step == StepLastPredict) begin
            dsel  <= 1'b0;
            state <= S_DIVL;
          end else if (step == StepLast) begin
            state <= S_FIN;
          end else begin
            state <= S_MULP;
          end
        end
        S_DIVL: begin
          dvd   <= {mag_of(dnum), FracBits'(0)};
          dvs   <= mag_of(dden);
          dneg  <= dnum[WordWidth-1] != dden[WordWidth-1];
          dzero <= (dden == '0);
          rem   <= '0;
          quo   <= '0;
          cnt   <= CntWidth'(DivBits - 1);
          state <= S_DIVR;
        end
        S_DIVR: begin
          rem <= rge ? WordWidth'(rsh - {1'b0, dvs}) : rsh[WordWidth-1:0];
          quo <= quo_next;
          dvd <= {dvd[DivBits-2:0], 1'b0};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            if (!dsel) begin
              k0    <= kq;
              dsel  <= 1'b1;
              state <= S_DIVL;
            end else begin
              k1    <= kq;
              step  <= StepAngle;
              state <= S_MULP;
            end
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            ang            <= a;
            rat            <= r;
            angle_estimate <= a[26:0];
            rate_estimate  <= r;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_MULP && step == 4'd0))
    else $error("item did not start the sequence");
  a_fin: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> (step == StepLast + 4'd1))
    else $error("sequence ended early");
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_angle: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> (a <= PiQ && a >= -PiQ))
    else $error("angle outside wrap range");

endmodule
